// ----- hdl/pfade_pkg.sv -----
// shared constants, types and constant tables of the palette fade unit
package pfade_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int FADE_STEPS      = 64;

    localparam int LEVEL_NEUTRAL = 100;
    localparam int LEVEL_MAX     = 200;
    localparam int FULL          = 255;

    localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
    localparam int STEP_W = $clog2(FADE_STEPS + 1);
    localparam int SUM_W  = ((STEP_W > 8) ? STEP_W : 8) + 2;

    // blend divide by FADE_STEPS folded into per-step weights, exact for sums up to 200 * steps
    localparam int BLEND_SH  = $clog2(LEVEL_MAX * FADE_STEPS * FADE_STEPS + 1);
    localparam int BLEND_MUL = ((1 << BLEND_SH) + FADE_STEPS - 1) / FADE_STEPS;
    localparam int WEIGHT_W  = BLEND_SH + 1;
    localparam int ACC_W     = 8 + WEIGHT_W + 1;

    // percent divide by reciprocal, exact for products up to 255 * 100
    localparam int PROD_W    = $clog2(FULL * LEVEL_NEUTRAL + 1);
    localparam int PCT_SH    = $clog2(FULL * LEVEL_NEUTRAL * LEVEL_NEUTRAL + 1);
    localparam int PCT_MUL   = ((1 << PCT_SH) + LEVEL_NEUTRAL - 1) / LEVEL_NEUTRAL;
    localparam int PCT_MUL_W = $clog2(PCT_MUL + 1);
    localparam int QUOT_W    = PROD_W + PCT_MUL_W;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_START  = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_LOOKUP = 2'd3
    } t_mode;

    // element 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic              start;
        logic              tick;
        t_rgb              target;
        logic signed [7:0] speed;
    } t_fade_cmd;

    typedef struct packed {
        logic fading;
        t_rgb level;
    } t_fade_stat;

    typedef logic [WEIGHT_W-1:0] t_weight_tab [FADE_STEPS+1];
    typedef logic [IDX_W-1:0]    t_idx_tab    [256];

    function automatic t_weight_tab build_weights();
        t_weight_tab tab;
        for (int s = 0; s <= FADE_STEPS; s++) begin
            tab[s] = WEIGHT_W'(s * BLEND_MUL);
        end
        return tab;
    endfunction

    function automatic t_idx_tab build_idx_map();
        t_idx_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = IDX_W'(i % PALETTE_ENTRIES);
        end
        return tab;
    endfunction

endpackage

// ----- hdl/palette_fade_unit.sv -----
// palette fade unit top level: palette ram, fade state and lookup scaling
//
//   channel   handshake          words
//   input     i_valid / o_ready  i_mode i_index i_red i_green i_blue i_speed
//   output    o_valid / i_ready  o_fading o_level_* o_faded_*
//
// one word accepted per cycle while o_ready is high; each result is presented from
// three register stages
// (palette ram read, level product, percent divide into the output register)
// fade state is updated in the stage after the ram read, so every word sees the
// levels left by the word before it; palette writes land at acceptance
// reset clears the fade state and the valid flags; the palette ram holds garbage until written
// a held result freezes the whole pipeline; o_ready = !o_valid || i_ready
module palette_fade_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic signed [7:0] i_speed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_fading,
    output logic [7:0]  o_level_red,
    output logic [7:0]  o_level_green,
    output logic [7:0]  o_level_blue,
    output logic [7:0]  o_faded_red,
    output logic [7:0]  o_faded_green,
    output logic [7:0]  o_faded_blue
);

    import pfade_pkg::*;

    localparam t_idx_tab IDX_MAP = build_idx_map();

    logic              en;
    logic              accept;
    t_mode             in_mode;
    t_rgb              in_col;
    t_rgb              entry;
    t_fade_cmd         cmd;
    t_fade_stat        stat;
    t_rgb              faded;

    logic              r1_valid;
    t_mode             r1_mode;
    t_rgb              r1_col;
    logic signed [7:0] r1_speed;
    logic              r2_valid;

    logic              r_o_valid;
    logic              r_o_fading;
    t_rgb              r_o_level;
    t_rgb              r_o_faded;

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && en;
    assign in_mode = t_mode'(i_mode);
    assign in_col  = {i_blue, i_green, i_red};

    pfade_ram #(
        .WIDTH(24),
        .DEPTH(PALETTE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (accept && (in_mode == MODE_WRITE)),
        .i_re   (en),
        .i_addr (IDX_MAP[i_index]),
        .i_wdata(in_col),
        .o_rdata(entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= accept;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_mode  <= in_mode;
            r1_col   <= in_col;
            r1_speed <= i_speed;
        end
    end

    assign cmd.start  = en && r1_valid && (r1_mode == MODE_START);
    assign cmd.tick   = en && r1_valid && (r1_mode == MODE_TICK);
    assign cmd.target = r1_col;
    assign cmd.speed  = r1_speed;

    pfade_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_stat (stat)
    );

    pfade_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_lookup(r1_valid && (r1_mode == MODE_LOOKUP)),
        .i_entry (entry),
        .i_level (stat.level),
        .o_faded (faded)
    );

    // fade state registers already hold the state after the word leaving stage two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_fading <= stat.fading;
            r_o_level  <= stat.level;
            r_o_faded  <= faded;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_fading      = r_o_fading;
    assign o_level_red   = r_o_level[0];
    assign o_level_green = r_o_level[1];
    assign o_level_blue  = r_o_level[2];
    assign o_faded_red   = r_o_faded[0];
    assign o_faded_green = r_o_faded[1];
    assign o_faded_blue  = r_o_faded[2];

endmodule

// ----- hdl/pfade_ram.sv -----
// generic single-port ram with registered read
module pfade_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/pfade_ctrl.sv -----
// fade state: step counter, start and target levels, current levels
module pfade_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfade_pkg::t_fade_cmd  i_cmd,
    output pfade_pkg::t_fade_stat o_stat
);

    import pfade_pkg::*;

    localparam t_weight_tab WEIGHT = build_weights();

    logic              r_active, n_active;
    logic [STEP_W-1:0] r_step, n_step;
    logic signed [7:0] r_inc, n_inc;
    t_rgb              r_level, n_level;
    t_rgb              r_start, n_start;
    t_rgb              r_target, n_target;

    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] inc_ext;
    logic signed [SUM_W-1:0] step_sum;
    logic signed [SUM_W-1:0] clamp_ext;
    logic signed [SUM_W-1:0] next_sum;
    logic [STEP_W-1:0]       clamp_step;
    logic                    clamp_end;
    logic [WEIGHT_W-1:0]     w_target;
    logic [WEIGHT_W-1:0]     w_start;
    logic [ACC_W-1:0]        acc [3];
    t_rgb                    blend;
    t_rgb                    sat_target;
    logic                    neutral;
    logic                    next_out;

    assign step_ext = $signed({{(SUM_W-STEP_W){1'b0}}, r_step});
    assign inc_ext  = $signed({{(SUM_W-8){r_inc[7]}}, r_inc});
    assign step_sum = step_ext + inc_ext;

    always_comb begin
        priority if (step_sum < 0) begin
            clamp_step = '0;
            clamp_end  = 1'b1;
        end else if (step_sum >= $signed(SUM_W'(FADE_STEPS))) begin
            clamp_step = STEP_W'(FADE_STEPS);
            clamp_end  = 1'b1;
        end else begin
            clamp_step = step_sum[STEP_W-1:0];
            clamp_end  = 1'b0;
        end
    end

    assign w_target  = WEIGHT[clamp_step];
    assign w_start   = WEIGHT[STEP_W'(FADE_STEPS) - clamp_step];
    assign clamp_ext = $signed({{(SUM_W-STEP_W){1'b0}}, clamp_step});
    assign next_sum  = clamp_ext + inc_ext;
    assign next_out  = (next_sum < 0) || (next_sum > $signed(SUM_W'(FADE_STEPS)));

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c]        = ACC_W'(r_target[c]) * ACC_W'(w_target)
                            + ACC_W'(r_start[c]) * ACC_W'(w_start);
            blend[c]      = acc[c][BLEND_SH +: 8];
            sat_target[c] = (i_cmd.target[c] > 8'(LEVEL_MAX)) ? 8'(LEVEL_MAX)
                                                               : i_cmd.target[c];
        end
        neutral = (blend[0] == 8'(LEVEL_NEUTRAL)) && (blend[1] == 8'(LEVEL_NEUTRAL))
                  && (blend[2] == 8'(LEVEL_NEUTRAL));
    end

    always_comb begin
        n_active = r_active;
        n_step   = r_step;
        n_inc    = r_inc;
        n_level  = r_level;
        n_start  = r_start;
        n_target = r_target;
        if (i_cmd.start) begin
            n_active = 1'b1;
            n_step   = '0;
            n_inc    = i_cmd.speed;
            n_start  = r_level;
            n_target = sat_target;
        end else if (i_cmd.tick && r_active) begin
            n_step   = clamp_step;
            n_level  = blend;
            // ends at a bound, or when neutral and the next tick would leave the range
            n_active = !clamp_end && !(next_out && neutral);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= STEP_W'(FADE_STEPS);
            r_inc    <= '0;
            r_level  <= {3{8'(LEVEL_NEUTRAL)}};
            r_start  <= {3{8'(LEVEL_NEUTRAL)}};
            r_target <= {3{8'(LEVEL_NEUTRAL)}};
        end else begin
            r_active <= n_active;
            r_step   <= n_step;
            r_inc    <= n_inc;
            r_level  <= n_level;
            r_start  <= n_start;
            r_target <= n_target;
        end
    end

    assign o_stat.fading = r_active;
    assign o_stat.level  = r_level;

endmodule

// ----- hdl/pfade_scale.sv -----
// scaling of a looked-up entry by the current levels: product registered, then percent divide
module pfade_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_lookup,
    input  pfade_pkg::t_rgb i_entry,
    input  pfade_pkg::t_rgb i_level,
    output pfade_pkg::t_rgb o_faded
);

    import pfade_pkg::*;

    logic              r_look;
    logic [2:0]        r_up;
    t_rgb              r_val;
    logic [PROD_W-1:0] r_prod [3];

    logic [2:0]        up;
    logic [7:0]        mul_a [3];
    logic [7:0]        mul_b [3];
    logic [15:0]       prod [3];
    logic [QUOT_W-1:0] quot [3];
    logic [7:0]        q [3];

    // at or below neutral: v * level, above: (255 - v) * (level - 100)
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            up[c]    = i_level[c] > 8'(LEVEL_NEUTRAL);
            mul_a[c] = up[c] ? (8'(FULL) - i_entry[c]) : i_entry[c];
            mul_b[c] = up[c] ? (i_level[c] - 8'(LEVEL_NEUTRAL)) : i_level[c];
            prod[c]  = 16'(mul_a[c]) * 16'(mul_b[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look <= 1'b0;
        end else if (i_en) begin
            r_look <= i_lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_up  <= up;
            r_val <= i_entry;
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= prod[c][PROD_W-1:0];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            quot[c] = QUOT_W'(r_prod[c]) * QUOT_W'(PCT_MUL);
            q[c]    = quot[c][PCT_SH +: 8];
            if (!r_look) begin
                o_faded[c] = '0;
            end else if (r_up[c]) begin
                o_faded[c] = r_val[c] + q[c];
            end else begin
                o_faded[c] = q[c];
            end
        end
    end

endmodule

// ----- tb/palette_fade_unit_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the palette fade unit: queued words, own fade predictor
module palette_fade_unit_tb;
    import pfade_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT     = 32;
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 650;
    localparam int RANDOM_WORDS = 550;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_mode             mode;
        logic [7:0]        index;
        t_rgb              color;
        logic signed [7:0] speed;
    } t_pal_word;

    typedef struct packed {
        logic fading;
        t_rgb level;
        t_rgb faded;
    } t_fade_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_mode;
    logic [7:0]        i_index;
    logic [7:0]        i_red;
    logic [7:0]        i_green;
    logic [7:0]        i_blue;
    logic signed [7:0] i_speed;
    logic              o_valid;
    logic              i_ready;
    logic              o_fading;
    logic [7:0]        o_level_red;
    logic [7:0]        o_level_green;
    logic [7:0]        o_level_blue;
    logic [7:0]        o_faded_red;
    logic [7:0]        o_faded_green;
    logic [7:0]        o_faded_blue;

    palette_fade_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_index       (i_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_speed       (i_speed),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_fading      (o_fading),
        .o_level_red   (o_level_red),
        .o_level_green (o_level_green),
        .o_level_blue  (o_level_blue),
        .o_faded_red   (o_faded_red),
        .o_faded_green (o_faded_green),
        .o_faded_blue  (o_faded_blue)
    );

    t_pal_word    pend_words[$];
    t_fade_result results_due[$];
    t_pal_word    held_word;
    logic         word_taken = 1'b0;

    int cycle_count   = 0;
    int total_words   = 0;
    int words_in      = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int lookups_done  = 0;
    int fades_started = 0;
    int fades_done    = 0;
    logic quiet;

    // predicted block state
    t_rgb pal_mem [PALETTE_ENTRIES];
    logic fade_on   = 1'b0;
    int   step_pos  = FADE_STEPS;
    int   fade_incr = 0;
    t_rgb lvl_now   = {3{8'(LEVEL_NEUTRAL)}};
    t_rgb lvl_from  = {3{8'(LEVEL_NEUTRAL)}};
    t_rgb lvl_to    = {3{8'(LEVEL_NEUTRAL)}};

    // stimulus side bookkeeping so lookups only hit written entries
    logic       idx_written [256];
    logic [7:0] written_idx[$];

    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int fade_channel(int v, int lvl);
        if (lvl <= LEVEL_NEUTRAL) begin
            return (v * lvl) / LEVEL_NEUTRAL;
        end
        return v + ((FULL - v) * (lvl - LEVEL_NEUTRAL)) / LEVEL_NEUTRAL;
    endfunction

    task automatic apply_word(input t_pal_word w);
        t_fade_result r;
        int           idx;
        int           v;
        int           next;
        logic         neutral;
        r   = '0;
        idx = int'(w.index) % PALETTE_ENTRIES;
        unique case (w.mode)
            MODE_WRITE: begin
                pal_mem[idx] = w.color;
            end
            MODE_START: begin
                fade_incr = int'($signed(w.speed));
                step_pos  = 0;
                fade_on   = 1'b1;
                lvl_from  = lvl_now;
                for (int c = 0; c < 3; c++) begin
                    lvl_to[c] = (int'(w.color[c]) > LEVEL_MAX) ? 8'(LEVEL_MAX) : w.color[c];
                end
                fades_started++;
            end
            MODE_TICK: begin
                if (fade_on) begin
                    neutral  = 1'b1;
                    step_pos = step_pos + fade_incr;
                    if (step_pos < 0) begin
                        step_pos = 0;
                        fade_on  = 1'b0;
                    end
                    if (step_pos >= FADE_STEPS) begin
                        step_pos = FADE_STEPS;
                        fade_on  = 1'b0;
                    end
                    for (int c = 0; c < 3; c++) begin
                        v = (int'(lvl_to[c]) * step_pos +
                             int'(lvl_from[c]) * (FADE_STEPS - step_pos)) / FADE_STEPS;
                        lvl_now[c] = 8'(v);
                        if (v != LEVEL_NEUTRAL) begin
                            neutral = 1'b0;
                        end
                    end
                    // neutral levels end the fade early when the next step would overshoot
                    next = step_pos + fade_incr;
                    if ((next < 0 || next > FADE_STEPS) && neutral) begin
                        fade_on = 1'b0;
                    end
                    if (!fade_on) begin
                        fades_done++;
                    end
                end
            end
            default: begin
                for (int c = 0; c < 3; c++) begin
                    r.faded[c] = 8'(fade_channel(int'(pal_mem[idx][c]), int'(lvl_now[c])));
                end
                lookups_done++;
            end
        endcase
        r.fading = fade_on;
        r.level  = lvl_now;
        results_due.push_back(r);
    endtask

    task automatic queue_word(input t_mode m, input int idx, input int red, input int green,
                              input int blue, input int spd);
        t_pal_word w;
        w.mode     = m;
        w.index    = 8'(idx);
        w.color[0] = 8'(red);
        w.color[1] = 8'(green);
        w.color[2] = 8'(blue);
        w.speed    = 8'(spd);
        if (m == MODE_WRITE && !idx_written[w.index]) begin
            idx_written[w.index] = 1'b1;
            written_idx.push_back(w.index);
        end
        pend_words.push_back(w);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    function automatic int pick_speed();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return $urandom_range(1, 64);
        end else if (p < 80) begin
            return -int'($urandom_range(1, 64));
        end
        return $urandom_range(0, 255);
    endfunction

    // input side: once the held word is taken, a new word goes out at the falling edge unless a random idle is drawn
    always @(negedge i_clk) begin : word_driver
        t_pal_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_taken) begin
            word_taken = 1'b0;
            if (pend_words.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                w         = pend_words.pop_front();
                held_word = w;
                i_mode    <= w.mode;
                i_index   <= w.index;
                i_red     <= w.color[0];
                i_green   <= w.color[1];
                i_blue    <= w.color[2];
                i_speed   <= w.speed;
                i_valid   <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            apply_word(held_word);
            words_in++;
            word_taken = 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_fade_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                $error("result word with no expectation pending");
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("fading", want.fading, o_fading);
                check_field("level_red", want.level[0], o_level_red);
                check_field("level_green", want.level[1], o_level_green);
                check_field("level_blue", want.level[2], o_level_blue);
                check_field("faded_red", want.faded[0], o_faded_red);
                check_field("faded_green", want.faded[1], o_faded_green);
                check_field("faded_blue", want.faded[2], o_faded_blue);
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int tr;
        int tg;
        int tb;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_mode  = MODE_WRITE;
        i_index = '0;
        i_red   = '0;
        i_green = '0;
        i_blue  = '0;
        i_speed = '0;
        for (int i = 0; i < 256; i++) begin
            idx_written[i] = 1'b0;
        end

        // directed: extremes, idle tick, saturation, zero and out-of-range speed,
        // restart mid fade, early end on neutral levels
        queue_word(MODE_WRITE, 0, 0, 0, 0, 0);
        queue_word(MODE_WRITE, 255, 255, 255, 255, 0);
        queue_word(MODE_WRITE, 128, 'hAA, 'h55, 'h0F, 0);
        queue_word(MODE_LOOKUP, 0, 0, 0, 0, 0);
        queue_word(MODE_LOOKUP, 255, 0, 0, 0, 0);
        queue_word(MODE_LOOKUP, 128, 0, 0, 0, 0);
        queue_word(MODE_TICK, 0, 0, 0, 0, 0);
        queue_word(MODE_START, 0, 0, 200, 255, 64);
        queue_word(MODE_LOOKUP, 255, 0, 0, 0, 0);
        queue_word(MODE_TICK, 0, 0, 0, 0, 0);
        queue_word(MODE_LOOKUP, 128, 0, 0, 0, 0);
        queue_word(MODE_LOOKUP, 255, 0, 0, 0, 0);
        queue_word(MODE_START, 0, 50, 150, 100, 0);
        queue_word(MODE_TICK, 0, 0, 0, 0, 0);
        queue_word(MODE_START, 0, 120, 80, 255, 127);
        queue_word(MODE_TICK, 0, 0, 0, 0, 0);
        queue_word(MODE_START, 0, 100, 100, 100, -128);
        queue_word(MODE_TICK, 0, 0, 0, 0, 0);
        queue_word(MODE_LOOKUP, 128, 0, 0, 0, 0);
        queue_word(MODE_START, 0, 100, 100, 100, 64);
        queue_word(MODE_TICK, 0, 0, 0, 0, 0);
        queue_word(MODE_START, 0, 100, 100, 100, 40);
        queue_word(MODE_TICK, 0, 0, 0, 0, 0);
        queue_word(MODE_LOOKUP, 128, 0, 0, 0, 0);
        queue_word(MODE_START, 0, 30, 170, 90, 5);

        // random: a lookup stream with writes, fade starts and ticks mixed in
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            p = $urandom_range(0, 99);
            if (p < 12) begin
                queue_word(MODE_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (p < 20) begin
                if ($urandom_range(0, 99) < 15) begin
                    tr = LEVEL_NEUTRAL;
                    tg = LEVEL_NEUTRAL;
                    tb = LEVEL_NEUTRAL;
                end else begin
                    tr = $urandom_range(0, 255);
                    tg = $urandom_range(0, 255);
                    tb = $urandom_range(0, 255);
                end
                queue_word(MODE_START, $urandom_range(0, 255), tr, tg, tb, pick_speed());
            end else if (p < 55) begin
                queue_word(MODE_TICK, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
                queue_word(MODE_LOOKUP, written_idx[$urandom_range(0, written_idx.size() - 1)],
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255));
            end
        end
        total_words = pend_words.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_in < total_words || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words, %0d results checked, %0d of them palette lookups",
                 words_in, results_seen, lookups_done);
        $display("%0d fades started, %0d ran to an end, %0d mismatches",
                 fades_started, fades_done, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
